### rtl/svf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svf_pkg
// Shared types and constants for the state variable filter.
// ----------------------------------------------------------------------------
package svf_pkg;

    localparam int DEF_SAMPLE_WIDTH = 16;
    localparam int DEF_STATE_WIDTH  = 24;

    localparam int FREQ_W      = 15;
    localparam int DAMP_W      = 16;
    localparam int GAIN_W      = 15;
    localparam int COEF_W      = 16;
    localparam int DIGIT_W     = 4;
    localparam int NUM_DIGITS  = COEF_W / DIGIT_W;
    localparam int CNT_W       = $clog2(NUM_DIGITS);

    localparam int GAIN_BASE   = 3277;
    localparam int GAIN_SLOPE  = 13107;

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING = 1'b1;

    localparam logic [DAMP_W-1:0] DAMP_RESET = 16'd32768;

    typedef enum logic [1:0] {
        MODE_SILENT   = 2'd0,
        MODE_LOWPASS  = 2'd1,
        MODE_BANDPASS = 2'd2,
        MODE_HIGHPASS = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_GAIN = 3'd1,
        ST_LP   = 3'd2,
        ST_HP   = 3'd3,
        ST_BP   = 3'd4,
        ST_OUT  = 3'd5
    } state_t;

    // command to the digit-serial multiplier
    typedef struct packed {
        logic              start;
        logic [COEF_W-1:0] coef;
    } mac_cmd_t;

endpackage

### rtl/svf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svf_in_if / svf_out_if
// Valid/ready channels carrying filter input and output items.
// ----------------------------------------------------------------------------
interface svf_in_if #(
    parameter int SAMPLE_WIDTH = svf_pkg::DEF_SAMPLE_WIDTH
);
    import svf_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic [FREQ_W-1:0]              freq_coef;

    modport source (output valid, output sample_in, output freq_coef, input ready);
    modport sink   (input valid, input sample_in, input freq_coef, output ready);
endinterface

interface svf_out_if #(
    parameter int SAMPLE_WIDTH = svf_pkg::DEF_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

### rtl/svf_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svf_mac
// Digit-serial multiplier: signed multiplicand times 16-bit unsigned
// coefficient, 4 coefficient bits per cycle, result floor(P / 2^15).
// The 15 bits shifted out below the result come out on prod_lo.
// ----------------------------------------------------------------------------
module svf_mac #(
    parameter int MW = svf_pkg::DEF_STATE_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  svf_pkg::mac_cmd_t             cmd,
    input  logic signed [MW-1:0]          mult,
    output logic signed [MW+1:0]          prod,
    output logic [svf_pkg::COEF_W-2:0]    prod_lo,
    output logic                          done
);
    import svf_pkg::*;

    localparam int AW = MW + 5;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [COEF_W-1:0]     coef_reg, coef_next;
    logic signed [MW-1:0]  m_reg, m_next;
    logic signed [AW-1:0]  acc_reg, acc_next;
    logic [COEF_W-1:0]     lo_reg, lo_next;

    logic [DIGIT_W-1:0]    digit;
    logic signed [AW-1:0]  term;
    logic signed [AW-1:0]  sum;
    logic                  last;

    assign digit = coef_reg[DIGIT_W-1:0];
    assign term  = AW'($signed({1'b0, digit})) * AW'(m_reg);
    assign sum   = acc_reg + term;
    assign last  = (cnt_reg == CNT_W'(NUM_DIGITS - 1));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        coef_next = coef_reg;
        m_next    = m_reg;
        acc_next  = acc_reg;
        lo_next   = lo_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            coef_next = cmd.coef;
            m_next    = mult;
            acc_next  = '0;
            lo_next   = '0;
        end
        else if (busy_reg)
        begin
            coef_next = coef_reg >> DIGIT_W;
            cnt_next  = cnt_reg + 1'b1;
            // last digit shifts one bit less: total shift is 15, not 16
            acc_next  = last ? (sum >>> (DIGIT_W - 1)) : (sum >>> DIGIT_W);
            // dropped low bits collect from the top; bit 0 ends up unused
            lo_next   = last ? {sum[DIGIT_W-2:0], lo_reg[COEF_W-1:DIGIT_W-1]}
                             : {sum[DIGIT_W-1:0], lo_reg[COEF_W-1:DIGIT_W]};
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        coef_reg <= coef_next;
        m_reg    <= m_next;
        acc_reg  <= acc_next;
        lo_reg   <= lo_next;
    end

    assign prod    = acc_reg[MW+1:0];
    assign prod_lo = lo_reg[COEF_W-1:1];
    assign done    = done_reg;

endmodule

### rtl/state_variable_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// state_variable_filter_top
// Two-pole state variable filter, fixed point, one shared digit-serial
// multiplier sequenced over gain, lowpass, highpass, bandpass and output.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  in_ch     in    valid / ready    sample_in, freq_coef
//  out_ch    out   valid / ready    sample_out
//  cfg       in    cfg_we           cfg_index, cfg_data (mode, damping)
//
//  An item is accepted, then runs five multiplies on the single MAC, each
//  in the steps issue, four 4-bit coefficient digits and write-back.
//  Input is taken only in idle; a finished result waits in the output register
//  while the next item runs. The final write-back stalls if that register is
//  still full. Reset clears the filter state, mode = lowpass, damping = 1.0.
// ----------------------------------------------------------------------------
module state_variable_filter_top #(
    parameter int SAMPLE_WIDTH = svf_pkg::DEF_SAMPLE_WIDTH,
    parameter int STATE_WIDTH  = svf_pkg::DEF_STATE_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    svf_in_if.sink                             in_ch,
    svf_out_if.source                          out_ch,
    input  logic                               cfg_we,
    input  logic [svf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [svf_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import svf_pkg::*;

    localparam int SW = STATE_WIDTH;
    localparam int XW = SAMPLE_WIDTH;
    // state frac bits minus sample frac bits
    localparam int D  = SW - XW - 4;
    localparam int AW = SW + XW + 2;
    // full product shift from tap * gain down to sample format
    localparam int OS = COEF_W - 1 + D;

    state_t                state_reg, state_next;
    logic                  first_reg, first_next;
    logic                  out_valid_reg;
    mode_t                 mode_reg;
    logic [DAMP_W-1:0]     damping_reg;
    logic signed [SW-1:0]  lp_reg, bp_reg, hp_reg;
    logic signed [XW-1:0]  x_reg;
    logic [FREQ_W-1:0]     f_reg;
    logic [GAIN_W-1:0]     gain_reg;
    logic signed [XW-1:0]  out_data_reg;

    mac_cmd_t              mac_cmd;
    logic signed [SW-1:0]  mac_mult;
    logic signed [SW+1:0]  mac_prod;
    logic [COEF_W-2:0]     mac_lo;
    logic                  mac_done;

    logic                  step_done;
    logic                  out_load;
    logic                  accept;
    logic signed [SW-1:0]  tap;

    logic signed [AW-1:0]      x_wide;
    logic signed [SW-1:0]      xs;
    logic signed [SW+3:0]      lp_sum, hp_sum, bp_sum;
    logic signed [SW-1:0]      lp_sat, hp_sat, bp_sat;
    logic signed [SW+COEF_W:0] p_full;
    logic signed [AW-1:0]      y_wide;
    logic signed [XW-1:0]      y_sat;

    function automatic logic signed [SW-1:0] sat_state(input logic signed [SW+3:0] v);
        logic [4:0] top;
        top = v[SW+3:SW-1];
        if ((&top) || !(|top))
            return v[SW-1:0];
        else if (v[SW+3])
            return {1'b1, {(SW-1){1'b0}}};
        else
            return {1'b0, {(SW-1){1'b1}}};
    endfunction

    svf_mac #(.MW(SW)) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mac_cmd),
        .mult    (mac_mult),
        .prod    (mac_prod),
        .prod_lo (mac_lo),
        .done    (mac_done)
    );

    // full-precision product of the last multiply
    assign p_full = {mac_prod, mac_lo};

    // sample into state format, and scaled product back to sample format
    generate
        if (D >= 0)
        begin : g_up
            assign x_wide = AW'(x_reg) <<< D;
        end
        else
        begin : g_down
            localparam int ND = -D;
            assign x_wide = AW'(x_reg) >>> ND;
        end
        if (OS >= 0)
        begin : g_out_down
            assign y_wide = AW'(p_full >>> OS);
        end
        else
        begin : g_out_up
            assign y_wide = AW'(p_full) <<< (-OS);
        end
    endgenerate

    always_comb
    begin
        if ((&x_wide[AW-1:SW-1]) || !(|x_wide[AW-1:SW-1]))
            xs = x_wide[SW-1:0];
        else if (x_wide[AW-1])
            xs = {1'b1, {(SW-1){1'b0}}};
        else
            xs = {1'b0, {(SW-1){1'b1}}};

        if ((&y_wide[AW-1:XW-1]) || !(|y_wide[AW-1:XW-1]))
            y_sat = y_wide[XW-1:0];
        else if (y_wide[AW-1])
            y_sat = {1'b1, {(XW-1){1'b0}}};
        else
            y_sat = {1'b0, {(XW-1){1'b1}}};
    end

    assign lp_sum = (SW+4)'(lp_reg) + (SW+4)'(mac_prod);
    assign hp_sum = (SW+4)'(xs) - (SW+4)'(lp_reg) - (SW+4)'(mac_prod);
    assign bp_sum = (SW+4)'(bp_reg) + (SW+4)'(mac_prod);
    assign lp_sat = sat_state(lp_sum);
    assign hp_sat = sat_state(hp_sum);
    assign bp_sat = sat_state(bp_sum);

    always_comb
    begin
        case (mode_reg)
            MODE_SILENT:   tap = '0;
            MODE_LOWPASS:  tap = lp_reg;
            MODE_BANDPASS: tap = bp_reg;
            MODE_HIGHPASS: tap = hp_reg;
            default:       tap = lp_reg;
        endcase
    end

    // MAC result is valid once done is up and the issue cycle is past
    assign step_done = mac_done && !first_reg;
    assign accept    = in_ch.valid && (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_OUT) && step_done && (!out_valid_reg || out_ch.ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        first_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_GAIN;
                    first_next = 1'b1;
                end
            end
            ST_GAIN:
            begin
                if (step_done)
                begin
                    state_next = ST_LP;
                    first_next = 1'b1;
                end
            end
            ST_LP:
            begin
                if (step_done)
                begin
                    state_next = ST_HP;
                    first_next = 1'b1;
                end
            end
            ST_HP:
            begin
                if (step_done)
                begin
                    state_next = ST_BP;
                    first_next = 1'b1;
                end
            end
            ST_BP:
            begin
                if (step_done)
                begin
                    state_next = ST_OUT;
                    first_next = 1'b1;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs: MAC operands per step
    always_comb
    begin
        mac_cmd.start = first_reg && (state_reg != ST_IDLE);
        mac_cmd.coef  = '0;
        mac_mult      = '0;
        in_ch.ready   = (state_reg == ST_IDLE);
        case (state_reg)
            ST_GAIN:
            begin
                mac_cmd.coef = COEF_W'(GAIN_SLOPE);
                mac_mult     = SW'($signed({1'b0, damping_reg}));
            end
            ST_LP:
            begin
                mac_cmd.coef = {1'b0, f_reg};
                mac_mult     = bp_reg;
            end
            ST_HP:
            begin
                mac_cmd.coef = damping_reg;
                mac_mult     = bp_reg;
            end
            ST_BP:
            begin
                mac_cmd.coef = {1'b0, f_reg};
                mac_mult     = hp_reg;
            end
            ST_OUT:
            begin
                mac_cmd.coef = {1'b0, gain_reg};
                mac_mult     = tap;
            end
            default:
            begin
                mac_cmd.coef = '0;
                mac_mult     = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_LOWPASS;
            damping_reg   <= DAMP_RESET;
            lp_reg        <= '0;
            bp_reg        <= '0;
            hp_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MODE:    mode_reg    <= mode_t'(cfg_data[1:0]);
                    REG_DAMPING: damping_reg <= cfg_data[DAMP_W-1:0];
                    default:     ;
                endcase
            end

            if (step_done && (state_reg == ST_LP))
                lp_reg <= lp_sat;
            if (step_done && (state_reg == ST_HP))
                hp_reg <= hp_sat;
            if (step_done && (state_reg == ST_BP))
                bp_reg <= bp_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= in_ch.sample_in;
            f_reg <= in_ch.freq_coef;
        end
        if (step_done && (state_reg == ST_GAIN))
            gain_reg <= GAIN_W'(GAIN_BASE) + mac_prod[GAIN_W-1:0];
        if (out_load)
            out_data_reg <= y_sat;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.sample_out = out_data_reg;

endmodule

### tb/svf_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svf_result_checker
// Watches the filter channels and the config port. It keeps its own copy of
// the filter state, predicts each output sample as an item is accepted, and
// compares the output items in order. It reports a failure count and the
// number of results still due.
// ----------------------------------------------------------------------------
module svf_result_checker
    import svf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    svf_in_if                     in_ch,
    svf_out_if                    out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);

    localparam int SAMPLE_W    = DEF_SAMPLE_WIDTH;
    localparam int STATE_W     = DEF_STATE_WIDTH;
    localparam int COEF_FRAC   = 15;
    localparam int ALIGN_SHIFT = (STATE_W - 5) - (SAMPLE_W - 1);
    localparam int OUT_SHIFT   = (STATE_W - 5) + COEF_FRAC - (SAMPLE_W - 1);

    logic signed [STATE_W-1:0]  lowpass_q;
    logic signed [STATE_W-1:0]  bandpass_q;
    logic signed [STATE_W-1:0]  highpass_q;
    mode_t                      mode_q;
    logic [DAMP_W-1:0]          damping_q;

    logic signed [SAMPLE_W-1:0] expected_samples[$];
    int                         mismatches;

    function automatic longint clamp(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // advances the filter state by one sample; returns the output sample
    function automatic logic signed [SAMPLE_W-1:0] filter_sample(
        logic signed [SAMPLE_W-1:0] x,
        logic [FREQ_W-1:0]          f
    );
        longint xs;
        longint fv;
        longint dv;
        longint lp;
        longint bp;
        longint hp;
        longint tap;
        longint gain;
        longint y;
        fv = longint'(f);
        dv = longint'(damping_q);
        bp = longint'(bandpass_q);
        xs = clamp(longint'(x) <<< ALIGN_SHIFT, STATE_W);
        lp = clamp(longint'(lowpass_q) + ((fv * bp) >>> COEF_FRAC), STATE_W);
        hp = clamp(xs - lp - ((dv * bp) >>> COEF_FRAC), STATE_W);
        bp = clamp(bp + ((fv * hp) >>> COEF_FRAC), STATE_W);
        lowpass_q  = STATE_W'(lp);
        highpass_q = STATE_W'(hp);
        bandpass_q = STATE_W'(bp);
        case (mode_q)
            MODE_SILENT:   tap = 0;
            MODE_BANDPASS: tap = bp;
            MODE_HIGHPASS: tap = hp;
            default:       tap = lp;
        endcase
        gain = longint'(GAIN_BASE) + ((dv * longint'(GAIN_SLOPE)) >>> COEF_FRAC);
        y = clamp((tap * gain) >>> OUT_SHIFT, SAMPLE_W);
        return SAMPLE_W'(y);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [SAMPLE_W-1:0] want;
        if (!rst_n)
        begin
            lowpass_q  = '0;
            bandpass_q = '0;
            highpass_q = '0;
            mode_q     = MODE_LOWPASS;
            damping_q  = DAMP_RESET;
            expected_samples.delete();
            mismatches = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MODE:    mode_q = mode_t'(cfg_data[1:0]);
                    REG_DAMPING: damping_q = cfg_data[DAMP_W-1:0];
                    default:     ;
                endcase
            end
            // output side first, so an early item is not masked by a fresh one
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected output item sample_out=%0d",
                                 $realtime, out_ch.sample_out);
                    mismatches++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (out_ch.sample_out !== want)
                    begin
                        if (mismatches < 10)
                            $display("%0t: sample_out mismatch: expected %0d, got %0d",
                                     $realtime, want, out_ch.sample_out);
                        mismatches++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_samples.push_back(filter_sample(in_ch.sample_in,
                                                         in_ch.freq_coef));
            errors  <= mismatches;
            pending <= expected_samples.size();
        end
    end

endmodule

### tb/state_variable_filter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// state_variable_filter_top_tb
// Drives the state variable filter with a short directed set and then random
// phases of samples (noise, square waves, random walks) under several mode
// and damping settings, with random stalls on both channels and one long
// output hold-off. The checker next to the block predicts and compares.
// ----------------------------------------------------------------------------
module state_variable_filter_top_tb;

    import svf_pkg::*;

    localparam int SAMPLE_W    = DEF_SAMPLE_WIDTH;
    localparam int NUM_PHASES  = 16;
    localparam int PHASE_ITEMS = 125;
    localparam int HOLD_PHASE  = 8;
    localparam int LONG_HOLD   = 400;
    localparam int CYCLE_LIMIT = 1000000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending_results;
    int cycle_count = 0;
    int hold_count;
    bit idle_on;
    bit long_hold;
    bit hold_served;

    svf_in_if  #(.SAMPLE_WIDTH(SAMPLE_W)) in_ch ();
    svf_out_if #(.SAMPLE_WIDTH(SAMPLE_W)) out_ch ();

    state_variable_filter_top #(
        .SAMPLE_WIDTH (SAMPLE_W),
        .STATE_WIDTH  (DEF_STATE_WIDTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    svf_result_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (fail_count),
        .pending   (pending_results)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // output side: random stall bursts, plus one long hold-off on request
    initial
    begin
        forever
        begin
            if (long_hold && !hold_served)
            begin
                hold_served = 1'b1;
                out_ch.ready <= 1'b0;
                for (hold_count = 0; hold_count < LONG_HOLD; hold_count++)
                    @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    // returns at the edge where the item is taken
    task automatic offer_sample(int s, int f);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= SAMPLE_W'(s);
        in_ch.freq_coef <= FREQ_W'(f);
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic program_filter(mode_t m, logic [DAMP_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MODE;
        cfg_data  <= CFG_DATA_W'(m);
        @(posedge clk);
        cfg_index <= REG_DAMPING;
        cfg_data  <= CFG_DATA_W'(d);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_W'(-32768);
            1:       return SAMPLE_W'(32767);
            2, 3, 4, 5: return SAMPLE_W'($urandom);
            default: return SAMPLE_W'(int'($urandom_range(0, 4096)) - 2048);
        endcase
    endfunction

    function automatic logic [FREQ_W-1:0] pick_freq();
        case ($urandom_range(0, 9))
            0, 1, 2: return FREQ_W'($urandom_range(0, 3000));
            3, 4, 5: return FREQ_W'($urandom);
            6:       return '0;
            7:       return '1;
            default: return FREQ_W'($urandom_range(1000, 16000));
        endcase
    endfunction

    initial
    begin
        mode_t             m;
        logic [DAMP_W-1:0] d;
        logic [FREQ_W-1:0] f;
        int                phase;
        int                n;
        int                style;
        int                amp;
        int                period;
        int                walk;

        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= REG_MODE;
        cfg_data        <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.sample_in <= '0;
        in_ch.freq_coef <= '0;
        idle_on     = 1'b1;
        long_hold   = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings: lowpass, damping 1.0
        offer_sample(32767, 32767);
        offer_sample(-32768, 32767);
        offer_sample(0, 0);
        offer_sample(-1, 1);
        offer_sample(32767, 0);
        offer_sample(-32768, 16384);
        wait_for_results();

        // no damping, full-scale square at top frequency: drives saturation
        program_filter(MODE_HIGHPASS, 16'd0);
        for (n = 0; n < 6; n++)
            offer_sample(n[0] ? -32768 : 32767, 32767);
        wait_for_results();

        // damping above one
        program_filter(MODE_BANDPASS, 16'hFFFF);
        offer_sample(32767, 20000);
        offer_sample(32767, 20000);
        offer_sample(-32768, 5000);
        offer_sample(100, 1);
        wait_for_results();

        // silent mode keeps the filter running
        program_filter(MODE_SILENT, 16'd40000);
        offer_sample(32767, 32767);
        offer_sample(-32768, 12345);
        offer_sample(7, 300);

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_for_results();
            case (phase)
                0:       begin m = MODE_LOWPASS;  d = 16'd0;     end
                1:       begin m = MODE_BANDPASS; d = 16'hFFFF;  end
                2:       begin m = MODE_HIGHPASS; d = 16'd1;     end
                3:       begin m = MODE_SILENT;   d = 16'd32767; end
                4:       begin m = MODE_HIGHPASS; d = 16'hFFFF;  end
                5:       begin m = MODE_BANDPASS; d = 16'd0;     end
                default:
                begin
                    m = mode_t'($urandom_range(0, 3));
                    d = ($urandom_range(0, 3) == 0) ? DAMP_RESET : DAMP_W'($urandom);
                end
            endcase
            program_filter(m, d);
            // last part of the run goes without idling
            idle_on = (phase < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
            if (phase == HOLD_PHASE)
                long_hold = 1'b1;
            style  = $urandom_range(0, 2);
            f      = pick_freq();
            amp    = $urandom_range(0, 32767);
            period = $urandom_range(1, 40);
            walk   = 0;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                case (style)
                    0: offer_sample(int'(pick_sample()), int'(pick_freq()));
                    1: offer_sample(((n / period) % 2) ? amp : -amp, int'(f));
                    default:
                    begin
                        walk += int'($urandom_range(0, 4000)) - 2000;
                        if (walk > 32767)
                            walk = 32767;
                        if (walk < -32768)
                            walk = -32768;
                        offer_sample(walk, int'(f));
                    end
                endcase
            end
        end

        wait_for_results();
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
